// ----- rtl/mpq_pkg.sv -----
// Shared types and constants for the max priority queue.
// Holds the transfer payload structs, status codes and the controller/datapath link.
package mpq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 8;
  localparam int PAY_W    = 32;
  localparam int OCC_W    = 7;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    FN_ENQ = 1'b0,
    FN_DEQ = 1'b1
  } func_t;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key_in;
    logic [PAY_W-1:0] payload_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] key_out;
    logic [PAY_W-1:0] payload_out;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic do_enq;
    logic do_deq;
    logic rep_full;
    logic rep_empty;
  } mpq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mpq_sts_t;

endpackage

// ----- rtl/max_priority_queue_by_key.sv -----
// Bounded max-priority queue: a sorted shift row of CAPACITY key/payload cells.
// Every item is one transfer in and one transfer out. In the shipped build
// (CAPACITY = 64) all cells compare the new key in parallel and shift in
// the same cycle, so a new item is taken every cycle while the result side
// keeps up. The single result register is what limits that rate; when the
// result waits for out_ready, input stalls until that transfer. An enqueue
// places the entry after every held entry with a key greater or equal, so
// larger keys leave first and equal keys leave in arrival order; it reports
// full (status 1) when occupancy is already CAPACITY.
// A dequeue returns the head entry, or reports empty (status 2) with key and
// payload zero. occupancy is the count after the operation (low 7 bits).
// Depends on mpq_pkg, mpq_ctrl and mpq_dp.
module max_priority_queue_by_key (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mpq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mpq_pkg::out_item_t out_data
);
  import mpq_pkg::*;

  // Command and status link between the controller and the cell row.
  mpq_cmd_t cmd;
  mpq_sts_t sts;

  // Controller: decode func, check full/empty, hold the result until its transfer.
  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_data.func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: insert in key order or drop at the head, advance the count, register the result.
  mpq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_key     (in_data.key_in),
    .in_payload (in_data.payload_in),
    .cmd        (cmd),
    .sts        (sts),
    .res        (out_data)
  );

endmodule

// ----- rtl/mpq_ctrl.sv -----
// Controller for the max priority queue: input/output handshake and operation decode.
// Depends on mpq_pkg; drives mpq_dp through mpq_cmd_t and reads mpq_sts_t.
module mpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  output logic              out_valid,
  input  logic              out_ready,
  input  mpq_pkg::mpq_sts_t sts,
  output mpq_pkg::mpq_cmd_t cmd
);
  import mpq_pkg::*;

  typedef enum logic {
    S_EMPTY,
    S_HOLD
  } state_t;

  state_t state_r;
  logic   accept;

  // Take a new item whenever the result slot is free or is being drained.
  assign in_ready  = (state_r == S_EMPTY) || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state_r == S_HOLD);

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    if (accept) begin
      if (func_t'(in_func) == FN_ENQ) begin
        cmd.do_enq   = !sts.full;
        cmd.rep_full = sts.full;
      end else begin
        cmd.do_deq    = !sts.empty;
        cmd.rep_empty = sts.empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EMPTY;
    end else begin
      case (state_r)
        S_EMPTY: begin
          if (accept) state_r <= S_HOLD;
        end
        S_HOLD: begin
          if (out_ready && !accept) state_r <= S_EMPTY;
        end
        default: state_r <= S_EMPTY;
      endcase
    end
  end

  a_load_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> $onehot({cmd.do_enq, cmd.do_deq, cmd.rep_full, cmd.rep_empty}))
    else $error("accepted item must resolve to exactly one action");

  a_no_op_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.load |-> !(cmd.do_enq || cmd.do_deq || cmd.rep_full || cmd.rep_empty))
    else $error("action issued without an accepted item");

  a_full_guard: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_enq |-> !sts.full)
    else $error("insert issued while queue is full");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item produced no result");

endmodule

// ----- rtl/mpq_dp.sv -----
// Datapath for the max priority queue: sorted row of key/payload cells, count, result register.
// Depends on mpq_pkg; commanded by mpq_ctrl.
module mpq_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [mpq_pkg::KEY_W-1:0] in_key,
  input  logic [mpq_pkg::PAY_W-1:0] in_payload,
  input  mpq_pkg::mpq_cmd_t         cmd,
  output mpq_pkg::mpq_sts_t         sts,
  output mpq_pkg::out_item_t        res
);
  import mpq_pkg::*;

  logic [KEY_W-1:0]       key_r [CAPACITY];
  logic [PAY_W-1:0]       pay_r [CAPACITY];
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic [CAPACITY-1:0]    keep;
  logic [CNT_W+OCC_W-1:0] occ_ext;
  out_item_t              res_r;
  out_item_t              res_nxt;

  assign sts.full  = (count_r == CNT_W'(CAPACITY));
  assign sts.empty = (count_r == '0);
  assign res       = res_r;

  // Cells holding a key >= the new key stay; the row is sorted, so this is a prefix.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keep[i] = (count_r > CNT_W'(i)) && (key_r[i] >= in_key);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.do_enq && !keep[g]) begin
          key_r[g] <= in_key;
          pay_r[g] <= in_payload;
        end else if (cmd.do_deq) begin
          key_r[g] <= key_r[g+1];
          pay_r[g] <= pay_r[g+1];
        end
      end
    end else if (g == CAPACITY - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (cmd.do_enq && !keep[g]) begin
          key_r[g] <= keep[g-1] ? in_key     : key_r[g-1];
          pay_r[g] <= keep[g-1] ? in_payload : pay_r[g-1];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.do_enq && !keep[g]) begin
          key_r[g] <= keep[g-1] ? in_key     : key_r[g-1];
          pay_r[g] <= keep[g-1] ? in_payload : pay_r[g-1];
        end else if (cmd.do_deq) begin
          key_r[g] <= key_r[g+1];
          pay_r[g] <= pay_r[g+1];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.do_enq)      count_nxt = count_r + CNT_W'(1);
    else if (cmd.do_deq) count_nxt = count_r - CNT_W'(1);
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_nxt};

  always_comb begin
    res_nxt             = '0;
    res_nxt.occupancy   = occ_ext[OCC_W-1:0];
    if (cmd.rep_full)       res_nxt.status = ST_FULL;
    else if (cmd.rep_empty) res_nxt.status = ST_EMPTY;
    else                    res_nxt.status = ST_OK;
    if (cmd.do_deq) begin
      res_nxt.key_out     = key_r[0];
      res_nxt.payload_out = pay_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) res_r <= res_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_enq |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow count");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_deq |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("remove did not shrink count");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> key_r[0] >= key_r[1])
    else $error("head cells out of order");

endmodule
